// ===== design/assert_macros.svh =====
// assertion macros shared by the dark run corner detector
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DRCD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DRCD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/drcd_pkg.sv =====
// types and constants of the dark run corner detector
`timescale 1ns / 1ps

package drcd_pkg;

	localparam int WINDOW_LEN_DEF = 100;
	localparam int MAX_DIM_DEF    = 2048;

	localparam int COLOR_W     = 8;
	localparam int BRIGHT_W    = 10;
	localparam int BRIGHT_MAX  = 765;
	localparam int FIELD_W     = 12;
	localparam int DIM_REG_W   = 12;
	localparam int THRESH_W    = 17;
	localparam int OFFSET_W    = 7;
	localparam int CFG_DATA_W  = 17;
	localparam int CFG_INDEX_W = 2;
	localparam int IN_DATA_W   = 24;
	localparam int OUT_DATA_W  = 72;

	localparam logic [DIM_REG_W-1:0] WIDTH_RST  = DIM_REG_W'(1920);
	localparam logic [DIM_REG_W-1:0] HEIGHT_RST = DIM_REG_W'(1080);
	localparam logic [THRESH_W-1:0]  THRESH_RST = THRESH_W'(21000);
	localparam logic [OFFSET_W-1:0]  OFFSET_RST = OFFSET_W'(50);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_DARK_THRESH  = 2'd2,
		REG_COL_OFFSET   = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic                was_full;
		logic                full_now;
		logic [BRIGHT_W-1:0] tail;
	} ring_status_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               top_found;
		logic [FIELD_W-1:0] top_row;
		logic [FIELD_W-1:0] top_col;
		logic [FIELD_W-1:0] bottom_row;
		logic [FIELD_W-1:0] bottom_col;
		logic               frame_end;
	} result_t;

endpackage

// ===== design/drcd_cell.sv =====
// one brightness cell of the window shift chain
`timescale 1ns / 1ps

module drcd_cell (
	input  logic                          clk,
	input  logic                          en,
	input  logic [drcd_pkg::BRIGHT_W-1:0] d,
	output logic [drcd_pkg::BRIGHT_W-1:0] q
);
	import drcd_pkg::*;

	logic [BRIGHT_W-1:0] val_q;

	always_ff @(posedge clk) begin
		if (en) begin
			val_q <= d;
		end
	end

	assign q = val_q;

endmodule

// ===== design/drcd_chain.sv =====
// chain of brightness cells holding the sliding window, with fill tracking
`timescale 1ns / 1ps

module drcd_chain #(
	parameter int WINDOW_LEN = drcd_pkg::WINDOW_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          shift,
	input  logic                          clear,
	input  logic [drcd_pkg::BRIGHT_W-1:0] din,
	output drcd_pkg::ring_status_t        status
);
	import drcd_pkg::*;

	localparam int PTR_W = $clog2(WINDOW_LEN);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(WINDOW_LEN - 1);

	logic [BRIGHT_W-1:0] tap [WINDOW_LEN];
	logic [PTR_W-1:0]    fill_q;
	logic                full_q;
	logic                fill_last;

	for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
		if (i == 0) begin : g_head
			drcd_cell u_cell (
				.clk (clk),
				.en  (shift),
				.d   (din),
				.q   (tap[i])
			);
		end else begin : g_body
			drcd_cell u_cell (
				.clk (clk),
				.en  (shift),
				.d   (tap[i-1]),
				.q   (tap[i])
			);
		end
	end

	assign fill_last = (fill_q == LAST_SLOT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			full_q <= 1'b0;
		end else if (clear) begin
			fill_q <= '0;
			full_q <= 1'b0;
		end else if (shift) begin
			fill_q <= fill_last ? '0 : fill_q + 1'b1;
			if (fill_last) begin
				full_q <= 1'b1;
			end
		end
	end

	assign status.was_full = full_q;
	assign status.full_now = full_q | fill_last;
	assign status.tail     = tap[WINDOW_LEN-1];

	`include "assert_macros.svh"

	`DRCD_ASSERT_NXT(a_full_after_wrap, shift && !clear && fill_last, full_q, "window not full after wrap")
	`DRCD_ASSERT_NXT(a_clear_empties, clear, !full_q && fill_q == '0, "clear left window state")

endmodule

// ===== design/dark_run_corner_detector.sv =====
// dark run corner detector: top level with config, window sum, corners and output skid
`timescale 1ns / 1ps
// an accepted word is registered into the output word that drives m_tvalid, or into the skid word while that one waits
// throughput: one pixel per cycle while s_tready is high; the window sum and corner state are registered on acceptance
// a two-word output skid keeps s_tready high while one result waits for m_tready
// reset: registers take their defaults, frame state and counters clear
// window cells are not cleared; they are read only after a full wrap of the window

module dark_run_corner_detector #(
	parameter int WINDOW_LEN = drcd_pkg::WINDOW_LEN_DEF,
	parameter int MAX_DIM    = drcd_pkg::MAX_DIM_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [drcd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [drcd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [drcd_pkg::IN_DATA_W-1:0]   s_tdata,  // pixel_red, pixel_green, pixel_blue
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// out_red, out_green, out_blue, top_row, top_col, bottom_row, bottom_col
	output logic [drcd_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                             m_tuser,  // top_found
	output logic                             m_tlast   // frame_end
);
	import drcd_pkg::*;

	localparam int SUM_W = $clog2(WINDOW_LEN * BRIGHT_MAX + 1);
	localparam int CMP_W = (SUM_W > THRESH_W) ? SUM_W : THRESH_W;
	localparam int CNT_W = $clog2(MAX_DIM);
	localparam int DIM_W = CNT_W + 1;
	localparam int CMP_D = (DIM_W > DIM_REG_W) ? DIM_W : DIM_REG_W;
	localparam logic [FIELD_W-1:0] NONE = '1;

	// config registers
	logic [DIM_REG_W-1:0] width_q;
	logic [DIM_REG_W-1:0] height_q;
	logic [THRESH_W-1:0]  thresh_q;
	logic [OFFSET_W-1:0]  offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			thresh_q <= THRESH_RST;
			offset_q <= OFFSET_RST;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_FRAME_WIDTH:  width_q  <= cfg_data[DIM_REG_W-1:0];
				REG_FRAME_HEIGHT: height_q <= cfg_data[DIM_REG_W-1:0];
				REG_DARK_THRESH:  thresh_q <= cfg_data[THRESH_W-1:0];
				REG_COL_OFFSET:   offset_q <= cfg_data[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped frame size
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] raw);
		logic [CMP_D-1:0] ext;
		ext = CMP_D'(raw);
		if (ext == '0) begin
			return DIM_W'(1);
		end else if (ext > CMP_D'(MAX_DIM)) begin
			return DIM_W'(MAX_DIM);
		end
		return DIM_W'(ext);
	endfunction

	logic [DIM_W-1:0] width_cl;
	logic [DIM_W-1:0] height_cl;

	assign width_cl  = clamp_dim(width_q);
	assign height_cl = clamp_dim(height_q);

	// handshake and skid
	result_t out_s1;
	logic    out_v_s1;
	result_t skid_q;
	logic    skid_v_q;
	logic    acc;
	logic    take;

	assign s_tready = !skid_v_q;
	assign acc      = s_tvalid && s_tready;
	assign take     = out_v_s1 && m_tready;

	// window chain
	logic [COLOR_W-1:0]  pix_r, pix_g, pix_b;
	logic [BRIGHT_W-1:0] bright;
	ring_status_t        ring;
	logic                frame_end;

	assign pix_r  = s_tdata[COLOR_W-1:0];
	assign pix_g  = s_tdata[2*COLOR_W-1:COLOR_W];
	assign pix_b  = s_tdata[3*COLOR_W-1:2*COLOR_W];
	assign bright = BRIGHT_W'(pix_r) + BRIGHT_W'(pix_g) + BRIGHT_W'(pix_b);

	drcd_chain #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (acc),
		.clear  (acc && frame_end),
		.din    (bright),
		.status (ring)
	);

	// window sum and corner tracking
	logic [SUM_W-1:0]   sum_q;
	logic [SUM_W-1:0]   sum_next;
	logic               seen_q;
	logic [FIELD_W-1:0] top_row_q, top_col_q, bot_row_q, bot_col_q;
	logic [CNT_W-1:0]   row_q, col_q;
	logic               match;
	logic               last_col, last_row;
	logic               seen_n;
	logic [FIELD_W-1:0] top_row_n, top_col_n, bot_row_n, bot_col_n;

	assign sum_next = sum_q - (ring.was_full ? SUM_W'(ring.tail) : '0) + SUM_W'(bright);
	assign match    = ring.full_now && (CMP_W'(sum_next) < CMP_W'(thresh_q));
	assign last_col = (DIM_W'(col_q) + 1'b1) >= width_cl;
	assign last_row = (DIM_W'(row_q) + 1'b1) >= height_cl;
	assign frame_end = last_col && last_row;

	always_comb begin
		seen_n    = seen_q;
		top_row_n = top_row_q;
		top_col_n = top_col_q;
		bot_row_n = bot_row_q;
		bot_col_n = bot_col_q;
		if (match) begin
			if (!seen_q) begin
				seen_n    = 1'b1;
				top_row_n = FIELD_W'(row_q);
				top_col_n = FIELD_W'(col_q) - FIELD_W'(offset_q);
			end else begin
				bot_row_n = FIELD_W'(row_q);
				bot_col_n = FIELD_W'(col_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			seen_q    <= 1'b0;
			top_row_q <= NONE;
			top_col_q <= NONE;
			bot_row_q <= NONE;
			bot_col_q <= NONE;
			row_q     <= '0;
			col_q     <= '0;
		end else if (acc) begin
			if (frame_end) begin
				sum_q     <= '0;
				seen_q    <= 1'b0;
				top_row_q <= NONE;
				top_col_q <= NONE;
				bot_row_q <= NONE;
				bot_col_q <= NONE;
				row_q     <= '0;
				col_q     <= '0;
			end else begin
				sum_q     <= sum_next;
				seen_q    <= seen_n;
				top_row_q <= top_row_n;
				top_col_q <= top_col_n;
				bot_row_q <= bot_row_n;
				bot_col_q <= bot_col_n;
				if (last_col) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// result word
	result_t res;

	assign res.red        = pix_r;
	assign res.green      = pix_g;
	assign res.blue       = pix_b;
	assign res.top_found  = seen_n;
	assign res.top_row    = top_row_n;
	assign res.top_col    = top_col_n;
	assign res.bottom_row = bot_row_n;
	assign res.bottom_col = bot_col_n;
	assign res.frame_end  = frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_s1 <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (take) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_s1 <= acc;
			end
		end else if (acc) begin
			if (out_v_s1) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_s1 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_v_q) begin
				out_s1 <= skid_q;
			end else if (acc) begin
				out_s1 <= res;
			end
		end else if (acc) begin
			if (out_v_s1) begin
				skid_q <= res;
			end else begin
				out_s1 <= res;
			end
		end
	end

	assign m_tvalid = out_v_s1;
	assign m_tdata  = {out_s1.bottom_col, out_s1.bottom_row, out_s1.top_col,
	                   out_s1.top_row, out_s1.blue, out_s1.green, out_s1.red};
	assign m_tuser  = out_s1.top_found;
	assign m_tlast  = out_s1.frame_end;

	`include "assert_macros.svh"

	`DRCD_ASSERT_IMP(a_skid_behind_main, skid_v_q, out_v_s1, "skid word without main word")
	`DRCD_ASSERT_NXT(a_frame_clear, acc && frame_end, sum_q == '0 && !seen_q && col_q == '0, "frame state not cleared")
	`DRCD_ASSERT_IMP(a_no_top_none, out_v_s1 && !out_s1.top_found, out_s1.top_row == NONE && out_s1.top_col == NONE, "top corner set without flag")
	`DRCD_ASSERT_IMP(a_seen_drop, $fell(seen_q), $past(acc && frame_end), "corner flag dropped inside frame")

endmodule

// ===== tb/dark_run_corner_detector_test.sv =====
// self-checking testbench for the dark run corner detector: directed and random pixel streams
`timescale 1ns / 1ps

module dark_run_corner_detector_test;

	import drcd_pkg::*;

	localparam int WIN           = WINDOW_LEN_DEF;
	localparam int DIM_MAX       = MAX_DIM_DEF;
	localparam int RANDOM_PIXELS = 1450;
	localparam int DRAIN_CYCLES  = 4;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_FRAME_WIDTH;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic [IN_DATA_W-1:0]   s_tdata   = '0;
	logic                   m_tready  = 1'b0;
	logic                   s_tready;
	logic                   m_tvalid;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;

	// window and corner state of the frame in flight
	logic [BRIGHT_W-1:0] bright_ring [WIN];
	int                  ring_slot;
	bit                  ring_full;
	int                  ring_sum;
	bit                  top_seen;
	logic [FIELD_W-1:0]  top_row_q;
	logic [FIELD_W-1:0]  top_col_q;
	logic [FIELD_W-1:0]  bot_row_q;
	logic [FIELD_W-1:0]  bot_col_q;
	int                  row_at;
	int                  col_at;

	logic [DIM_REG_W-1:0] width_reg  = WIDTH_RST;
	logic [DIM_REG_W-1:0] height_reg = HEIGHT_RST;
	logic [THRESH_W-1:0]  thresh_reg = THRESH_RST;
	logic [OFFSET_W-1:0]  offset_reg = OFFSET_RST;

	result_t pixel_results_due [$];
	int      mismatches     = 0;
	int      src_gap_max    = 0;
	int      sink_stall_max = 0;
	int      stall_left     = 0;
	int      stall_draw;

	dark_run_corner_detector u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #4 clk = ~clk;

	function automatic void clear_frame_state();
		ring_slot = WIN - 1;
		ring_full = 1'b0;
		ring_sum  = 0;
		top_seen  = 1'b0;
		top_row_q = '1;
		top_col_q = '1;
		bot_row_q = '1;
		bot_col_q = '1;
		row_at    = 0;
		col_at    = 0;
	endfunction

	function automatic result_t track_dark_run(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int      bright;
		int      w;
		int      h;
		bit      last_col;
		bit      last_row;
		result_t res;
		bright    = int'(r) + int'(g) + int'(b);
		ring_slot = (ring_slot + 1 >= WIN) ? 0 : ring_slot + 1;
		if (ring_full)
			ring_sum -= int'(bright_ring[ring_slot]);
		bright_ring[ring_slot] = BRIGHT_W'(bright);
		ring_sum += bright;
		if (ring_slot == WIN - 1)
			ring_full = 1'b1;
		if (ring_full && ring_sum < int'(thresh_reg)) begin
			if (!top_seen) begin
				top_seen  = 1'b1;
				top_row_q = FIELD_W'(row_at);
				top_col_q = FIELD_W'(col_at - int'(offset_reg));
			end else begin
				bot_row_q = FIELD_W'(row_at);
				bot_col_q = FIELD_W'(col_at);
			end
		end
		// sizes out of range saturate
		w = (width_reg == 0) ? 1 : (int'(width_reg) > DIM_MAX) ? DIM_MAX : int'(width_reg);
		h = (height_reg == 0) ? 1 : (int'(height_reg) > DIM_MAX) ? DIM_MAX : int'(height_reg);
		last_col = col_at + 1 >= w;
		last_row = row_at + 1 >= h;
		res.red        = r;
		res.green      = g;
		res.blue       = b;
		res.top_found  = top_seen;
		res.top_row    = top_row_q;
		res.top_col    = top_col_q;
		res.bottom_row = bot_row_q;
		res.bottom_col = bot_col_q;
		res.frame_end  = last_col && last_row;
		if (last_col && last_row) begin
			clear_frame_state();
		end else if (last_col) begin
			col_at = 0;
			row_at++;
		end else begin
			col_at++;
		end
		return res;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected 'h%0h, actual 'h%0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// output side stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else if (m_tready) begin
			if (m_tvalid) begin
				stall_draw = (sink_stall_max == 0) ? 0 : $urandom_range(0, sink_stall_max);
				if (stall_draw != 0) begin
					m_tready   <= 1'b0;
					stall_left <= stall_draw;
				end
			end
		end else begin
			if (stall_left <= 1)
				m_tready <= 1'b1;
			else
				stall_left <= stall_left - 1;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pixel_results_due.size() == 0) begin
				$display("%0t ns: unexpected word, expected none, actual 'h%0h", $time, m_tdata);
				mismatches++;
			end else begin
				want = pixel_results_due.pop_front();
				check_field("out_red",    want.red,        m_tdata[7:0]);
				check_field("out_green",  want.green,      m_tdata[15:8]);
				check_field("out_blue",   want.blue,       m_tdata[23:16]);
				check_field("top_row",    want.top_row,    m_tdata[35:24]);
				check_field("top_col",    want.top_col,    m_tdata[47:36]);
				check_field("bottom_row", want.bottom_row, m_tdata[59:48]);
				check_field("bottom_col", want.bottom_col, m_tdata[71:60]);
				check_field("top_found",  want.top_found,  m_tuser);
				check_field("frame_end",  want.frame_end,  m_tlast);
			end
		end
	end

	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int gap;
		gap = (src_gap_max == 0) ? 0 : $urandom_range(0, src_gap_max);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {b, g, r};
		do @(posedge clk); while (!s_tready);
		pixel_results_due.push_back(track_dark_run(r, g, b));
	endtask

	task automatic finish_stream();
		s_tvalid <= 1'b0;
		while (pixel_results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, int value);
		finish_stream();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH:  width_reg  = DIM_REG_W'(value);
			REG_FRAME_HEIGHT: height_reg = DIM_REG_W'(value);
			REG_DARK_THRESH:  thresh_reg = THRESH_W'(value);
			REG_COL_OFFSET:   offset_reg = OFFSET_W'(value);
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic test_pixel_extremes();
		src_gap_max    = 0;
		sink_stall_max = 11;
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hff, 8'hff, 8'hff);
		send_pixel(8'hff, 8'h00, 8'h00);
		send_pixel(8'h00, 8'hff, 8'h00);
		send_pixel(8'h00, 8'h00, 8'hff);
		send_pixel(8'haa, 8'h55, 8'haa);
		send_pixel(8'h55, 8'haa, 8'h55);
	endtask

	task automatic test_size_clamp();
		src_gap_max    = 11;
		sink_stall_max = 0;
		// zero size: every pixel closes a frame
		write_reg(REG_FRAME_WIDTH, 0);
		write_reg(REG_FRAME_HEIGHT, 0);
		repeat (3) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
		write_reg(REG_FRAME_WIDTH, 4095);
		write_reg(REG_FRAME_HEIGHT, 1);
		repeat (3) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic test_size_change_mid_frame();
		src_gap_max    = 11;
		sink_stall_max = 11;
		write_reg(REG_FRAME_WIDTH, 10);
		write_reg(REG_FRAME_HEIGHT, 2);
		repeat (6) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
		// column already past the new last column
		write_reg(REG_FRAME_WIDTH, 4);
		repeat (6) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
		// row already on the new last row
		write_reg(REG_FRAME_HEIGHT, 1);
		repeat (4) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic test_random_frames();
		int         sent;
		int         phase;
		int         phase_len;
		int         n;
		int         kind;
		int         run_len;
		int         dark_max;
		int         thresh;
		int         offset;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_PIXELS) begin
			case (phase)
				0: begin
					thresh = 131071;
					offset = 127;
				end
				1: begin
					thresh = 0;
					offset = 0;
				end
				default: begin
					case ($urandom_range(0, 5))
						0:       thresh = 131071;
						1:       thresh = 0;
						2:       thresh = 76501;
						default: thresh = $urandom_range(500, 25000);
					endcase
					offset = $urandom_range(0, 127);
				end
			endcase
			case ($urandom_range(0, 9))
				0:       write_reg(REG_FRAME_WIDTH, 0);
				1:       write_reg(REG_FRAME_WIDTH, ($urandom_range(0, 1) == 0) ? 2048 : 4095);
				default: write_reg(REG_FRAME_WIDTH, $urandom_range(1, 40));
			endcase
			write_reg(REG_FRAME_HEIGHT, ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8));
			write_reg(REG_DARK_THRESH, thresh);
			write_reg(REG_COL_OFFSET, offset);
			src_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 11;
			sink_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
			phase_len      = $urandom_range(40, 250);
			if (phase_len > RANDOM_PIXELS - sent)
				phase_len = RANDOM_PIXELS - sent;
			n              = 0;
			while (n < phase_len) begin
				kind     = $urandom_range(0, 9);
				run_len  = $urandom_range(1, 120);
				dark_max = $urandom_range(0, 40);
				for (int i = 0; i < run_len && n < phase_len; i++) begin
					if (kind < 6) begin
						r = 8'($urandom_range(0, dark_max));
						g = 8'($urandom_range(0, dark_max));
						b = 8'($urandom_range(0, dark_max));
					end else if (kind < 8) begin
						r = 8'($urandom_range(180, 255));
						g = 8'($urandom_range(180, 255));
						b = 8'($urandom_range(180, 255));
					end else begin
						r = 8'($urandom);
						g = 8'($urandom);
						b = 8'($urandom);
					end
					send_pixel(r, g, b);
					n++;
				end
			end
			sent += n;
			phase++;
		end
	endtask

	initial begin
		clear_frame_state();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pixel_extremes();
		test_size_clamp();
		test_size_change_mid_frame();
		test_random_frames();
		finish_stream();
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
